// ----- hw/rtl/cbp_pkg.sv -----
// Shared types, register codes and arithmetic helpers for the color bar pixel generator.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package cbp_pkg;

   localparam int unsigned BAR_COUNT_DEF  = 7;
   localparam int unsigned MAX_WIDTH_DEF  = 4096;
   localparam int unsigned MAX_HEIGHT_DEF = 4096;

   localparam int unsigned FRAME_W  = 20;   // frame number bits, one remainder step each
   localparam int unsigned NUM_W    = 21;   // remainder times width, one quotient step each
   localparam int unsigned LAST_STG = FRAME_W + 1 + NUM_W;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0] WHITE_LINE_LUMA = 8'd235;

   typedef enum logic [3:0] {
      REG_FRAME_WIDTH  = 4'd0,
      REG_FRAME_HEIGHT = 4'd1,
      REG_FPS          = 4'd2,
      REG_LINE_ENABLE  = 4'd3,
      REG_PALETTE_0    = 4'd4,
      REG_PALETTE_1    = 4'd5,
      REG_PALETTE_2    = 4'd6,
      REG_PALETTE_3    = 4'd7
   } reg_index_type;

   typedef struct packed {
      logic [12:0]      width;
      logic [12:0]      height;
      logic [7:0]       fps;
      logic             line_en;
      logic [3:0][47:0] palette;
   } cfg_type;

   typedef struct packed {
      logic        ok;
      logic [11:0] x;
      logic [2:0]  bar_l;
      logic [2:0]  bar_c;
      logic        bottom;
      logic [19:0] frame;
   } item_type;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] cb;
      logic [7:0] cr;
   } ycc_type;

   // floor(v / 5), exact for v below 16384
   function automatic logic [12:0] div5(input logic [12:0] v);
      logic [25:0] p;
      p = 26'(v) * 26'd3277;
      return {1'b0, p[25:14]};
   endfunction

   // count thresholds k*w that x*count reaches; clamps to count-1 by construction
   function automatic logic [2:0] bar_index(input logic [11:0] x, input logic [12:0] w,
                                            input int unsigned count);
      logic [16:0] xs;
      logic [16:0] kw;
      logic [2:0]  b;
      xs = 17'(x) * 17'(count);
      b  = 3'd0;
      for (int k = 1; k < 8; k++) begin
         kw = 17'(w) * 17'(k);
         if (k < int'(count) && xs >= kw) begin
            b = b + 3'd1;
         end
      end
      return b;
   endfunction

   function automatic logic [23:0] color_of(input logic [2:0] bar,
                                           input logic [3:0][47:0] pal);
      logic [47:0] pair;
      pair = pal[bar[2:1]];
      return bar[0] ? pair[47:24] : pair[23:0];
   endfunction

   // BT.601 studio range in 16.16 fixed point; sums never go negative
   function automatic ycc_type to_ycc(input logic [23:0] rgb);
      logic signed [31:0] r;
      logic signed [31:0] g;
      logic signed [31:0] b;
      logic signed [31:0] ty;
      logic signed [31:0] tb;
      logic signed [31:0] tr;
      ycc_type o;
      r  = {24'd0, rgb[23:16]};
      g  = {24'd0, rgb[15:8]};
      b  = {24'd0, rgb[7:0]};
      ty = 32'sd1048576 + 32'sd16843 * r + 32'sd33030 * g + 32'sd6423 * b;
      tb = 32'sd8388608 - 32'sd9699 * r - 32'sd19071 * g + 32'sd28770 * b;
      tr = 32'sd8388608 + 32'sd28770 * r - 32'sd24117 * g - 32'sd4653 * b;
      o.y  = ty[23:16];
      o.cb = tb[23:16];
      o.cr = tr[23:16];
      return o;
   endfunction

endpackage

// ----- hw/rtl/cbp_front.sv -----
// Front end: accepts a pixel request, checks settings and bounds, finds both bar indices.
// Depends on cbp_pkg; feeds cbp_fifo.
`timescale 1ns / 1ps

module cbp_front #(
   parameter int unsigned BAR_COUNT  = cbp_pkg::BAR_COUNT_DEF,
   parameter int unsigned MAX_WIDTH  = cbp_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = cbp_pkg::MAX_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [11:0]       pixel_x,
   input  logic [11:0]       pixel_y,
   input  logic [19:0]       frame_number,
   input  cbp_pkg::cfg_type  cfg,
   output logic              push,
   output cbp_pkg::item_type push_item
);

   logic              push_ff;
   logic              push_in;
   cbp_pkg::item_type item_ff;
   cbp_pkg::item_type item_in;
   logic              set_ok;
   logic              in_frame;
   logic [12:0]       band_row;

   // classify the beat
   always_comb begin
      set_ok = (cfg.width != 13'd0) && (cfg.height != 13'd0) &&
               !cfg.width[0] && !cfg.height[0] &&
               ({1'b0, cfg.width} <= 14'(MAX_WIDTH)) &&
               ({1'b0, cfg.height} <= 14'(MAX_HEIGHT)) && (cfg.fps != 8'd0);
      in_frame = ({1'b0, pixel_x} < cfg.width) && ({1'b0, pixel_y} < cfg.height);
      band_row = cfg.height - cbp_pkg::div5({1'b0, cfg.height[12:1]});
      item_in.ok     = set_ok && in_frame;
      item_in.x      = pixel_x;
      item_in.bar_l  = cbp_pkg::bar_index(pixel_x, cfg.width, BAR_COUNT);
      item_in.bar_c  = cbp_pkg::bar_index({pixel_x[11:1], 1'b0}, cfg.width, BAR_COUNT);
      item_in.bottom = ({1'b0, pixel_y} >= band_row);
      item_in.frame  = frame_number;
      push_in        = start && !busy;
   end

   // hold the classified beat for the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         push_ff <= 1'b0;
      end else begin
         push_ff <= push_in;
      end
      item_ff <= item_in;
   end

   assign push      = push_ff;
   assign push_item = item_ff;

endmodule

// ----- hw/rtl/cbp_fifo.sv -----
// Short queue between the front and back ends of the pixel generator.
// Depends on cbp_pkg for the item type and depth.
`timescale 1ns / 1ps

module cbp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cbp_pkg::item_type push_item,
   input  logic              pop,
   output cbp_pkg::item_type pop_item,
   output logic              not_empty,
   output logic              full
);

   localparam int unsigned DEPTH = cbp_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cbp_pkg::item_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff;
   logic [PTR_W-1:0]   wr_in;
   logic [PTR_W-1:0]   rd_ff;
   logic [PTR_W-1:0]   rd_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_pop;

   // advance pointers and count
   always_comb begin
      do_pop   = pop && (count_ff != '0);
      wr_in    = push ? ((wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = do_pop ? ((rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   assign pop_item  = mem_ff[rd_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue overflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue count out of range");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a beat");
`endif

endmodule

// ----- hw/rtl/cbp_back.sv -----
// Back end: line position divider pipeline, palette lookup and YCbCr conversion.
// Depends on cbp_pkg; drains cbp_fifo every cycle and drives the result strobe.
`timescale 1ns / 1ps

module cbp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  cbp_pkg::item_type in_item,
   input  cbp_pkg::cfg_type  cfg,
   output logic              pop,
   output logic              rsp_strobe,
   output logic [7:0]        rsp_luma,
   output logic [7:0]        rsp_chroma_blue,
   output logic [7:0]        rsp_chroma_red,
   output logic              rsp_pixel_valid
);

   localparam int unsigned LAST = cbp_pkg::LAST_STG;
   localparam int unsigned NW   = cbp_pkg::NUM_W;

   typedef struct packed {
      logic          ok;
      logic [11:0]   x;
      logic [2:0]    bar_l;
      logic [2:0]    bar_c;
      logic          bottom;
      logic [19:0]   frame;
      logic [7:0]    rem;
      logic [NW-1:0] num;
      logic [NW-1:0] quo;
   } pipe_type;

   logic     vld_ff [LAST+1];
   pipe_type st_ff  [LAST+1];
   pipe_type st_in  [LAST+1];

   // load a beat from the queue
   always_comb begin
      st_in[0].ok     = in_item.ok;
      st_in[0].x      = in_item.x;
      st_in[0].bar_l  = in_item.bar_l;
      st_in[0].bar_c  = in_item.bar_c;
      st_in[0].bottom = in_item.bottom;
      st_in[0].frame  = in_item.frame;
      st_in[0].rem    = '0;
      st_in[0].num    = '0;
      st_in[0].quo    = '0;
   end

   // frame mod fps, then remainder times width, then divide by fps; one bit a stage
   for (genvar s = 1; s <= LAST; s++) begin : g_stage
      if (s <= cbp_pkg::FRAME_W) begin : g_mod
         logic [8:0] r9;
         always_comb begin
            r9       = {st_ff[s-1].rem, st_ff[s-1].frame[cbp_pkg::FRAME_W-s]};
            st_in[s] = st_ff[s-1];
            if (r9 >= {1'b0, cfg.fps}) begin
               st_in[s].rem = 8'(r9 - {1'b0, cfg.fps});
            end else begin
               st_in[s].rem = r9[7:0];
            end
         end
      end else if (s == cbp_pkg::FRAME_W + 1) begin : g_mul
         always_comb begin
            st_in[s]     = st_ff[s-1];
            st_in[s].num = NW'(st_ff[s-1].rem) * NW'(cfg.width);
            st_in[s].rem = '0;
         end
      end else begin : g_div
         logic [8:0] r9;
         logic       ge;
         always_comb begin
            r9       = {st_ff[s-1].rem, st_ff[s-1].num[LAST-s]};
            ge       = (r9 >= {1'b0, cfg.fps});
            st_in[s] = st_ff[s-1];
            st_in[s].rem = ge ? 8'(r9 - {1'b0, cfg.fps}) : r9[7:0];
            st_in[s].quo = {st_ff[s-1].quo[NW-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= LAST; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
      for (int i = 0; i <= LAST; i++) begin
         st_ff[i] <= st_in[i];
      end
   end

   // convert colors and overlay the moving line
   pipe_type          fin;
   cbp_pkg::ycc_type  ycc_l;
   cbp_pkg::ycc_type  ycc_c;
   logic [13:0]       line_x;
   logic [13:0]       line_end;
   logic [13:0]       x14;
   logic              hit;
   logic              strobe_ff;
   logic [7:0]        luma_ff;
   logic [7:0]        cb_ff;
   logic [7:0]        cr_ff;
   logic              pv_ff;

   always_comb begin
      fin      = st_ff[LAST];
      ycc_l    = cbp_pkg::to_ycc(cbp_pkg::color_of(fin.bar_l, cfg.palette));
      ycc_c    = cbp_pkg::to_ycc(cbp_pkg::color_of(fin.bar_c, cfg.palette));
      line_x   = 14'(fin.quo);
      line_end = line_x + 14'(cbp_pkg::div5({3'd0, cfg.width[12:3]}));
      x14      = {2'd0, fin.x};
      hit      = cfg.line_en && fin.bottom && (x14 >= line_x) && (x14 < line_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_ff[LAST];
      end
      if (fin.ok) begin
         luma_ff <= hit ? cbp_pkg::WHITE_LINE_LUMA : ycc_l.y;
         cb_ff   <= ycc_c.cb;
         cr_ff   <= ycc_c.cr;
         pv_ff   <= 1'b1;
      end else begin
         luma_ff <= 8'd0;
         cb_ff   <= 8'd0;
         cr_ff   <= 8'd0;
         pv_ff   <= 1'b0;
      end
   end

   assign pop             = in_valid;
   assign rsp_strobe      = strobe_ff;
   assign rsp_luma        = luma_ff;
   assign rsp_chroma_blue = cb_ff;
   assign rsp_chroma_red  = cr_ff;
   assign rsp_pixel_valid = pv_ff;

endmodule

// ----- hw/rtl/color_bar_pixel_generator.sv -----
// Top level of the color bar pixel generator: settings registers, front, queue, back.
// Depends on cbp_pkg, cbp_front, cbp_fifo and cbp_back.
//
// Usage:
//  - Raise start with req_pixel_x, req_pixel_y and req_frame_number; the beat is taken
//    at a rising edge where start is high and busy is low.
//  - One result per request appears on the rsp_ ports for one cycle with rsp_strobe
//    high, through the front, queue, pipeline and output registers, in request order.
//  - Throughput is one pixel per clock. The latency comes from the moving-line
//    position: frame mod fps and (remainder * width) / fps are worked out one bit per
//    stage in a 42-stage pipeline, plus the front, queue and output registers.
//  - The receiver cannot stall; the back end drains the queue every cycle, so busy
//    stays low in normal use.
//  - Settings are written through csr_write_enable, csr_index and csr_write_data while
//    the block is idle; indexes beyond the palette are ignored.
//  - Synchronous reset restores 1920x1080, 30 fps, line on, black palette, and empties
//    the queue and pipeline.
`timescale 1ns / 1ps

module color_bar_pixel_generator #(
   parameter int unsigned BAR_COUNT  = cbp_pkg::BAR_COUNT_DEF,
   parameter int unsigned MAX_WIDTH  = cbp_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = cbp_pkg::MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_pixel_x,
   input  logic [11:0] req_pixel_y,
   input  logic [19:0] req_frame_number,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_luma,
   output logic [7:0]  rsp_chroma_blue,
   output logic [7:0]  rsp_chroma_red,
   output logic        rsp_pixel_valid,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_index,
   input  logic [47:0] csr_write_data
);

   cbp_pkg::cfg_type  cfg_ff;
   cbp_pkg::cfg_type  cfg_in;
   logic              push;
   cbp_pkg::item_type push_item;
   logic              pop;
   cbp_pkg::item_type pop_item;
   logic              not_empty;
   logic              full;

   // decode settings writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (cbp_pkg::reg_index_type'(csr_index))
            cbp_pkg::REG_FRAME_WIDTH:  cfg_in.width   = csr_write_data[12:0];
            cbp_pkg::REG_FRAME_HEIGHT: cfg_in.height  = csr_write_data[12:0];
            cbp_pkg::REG_FPS:          cfg_in.fps     = csr_write_data[7:0];
            cbp_pkg::REG_LINE_ENABLE:  cfg_in.line_en = csr_write_data[0];
            cbp_pkg::REG_PALETTE_0:    cfg_in.palette[0] = csr_write_data;
            cbp_pkg::REG_PALETTE_1:    cfg_in.palette[1] = csr_write_data;
            cbp_pkg::REG_PALETTE_2:    cfg_in.palette[2] = csr_write_data;
            cbp_pkg::REG_PALETTE_3:    cfg_in.palette[3] = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width   <= 13'd1920;
         cfg_ff.height  <= 13'd1080;
         cfg_ff.fps     <= 8'd30;
         cfg_ff.line_en <= 1'b1;
         cfg_ff.palette <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign busy = full;

   cbp_front #(
      .BAR_COUNT  (BAR_COUNT),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .pixel_x      (req_pixel_x),
      .pixel_y      (req_pixel_y),
      .frame_number (req_frame_number),
      .cfg          (cfg_ff),
      .push         (push),
      .push_item    (push_item)
   );

   cbp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .not_empty (not_empty),
      .full      (full)
   );

   cbp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (not_empty),
      .in_item         (pop_item),
      .cfg             (cfg_ff),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_luma        (rsp_luma),
      .rsp_chroma_blue (rsp_chroma_blue),
      .rsp_chroma_red  (rsp_chroma_red),
      .rsp_pixel_valid (rsp_pixel_valid)
   );

`ifndef ASSERT_OFF
   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_pixel_valid) |-> (rsp_luma >= 8'd16 && rsp_luma <= 8'd235))
      else $error("luma outside studio range");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_pixel_valid) |->
      (rsp_luma == 8'd0 && rsp_chroma_blue == 8'd0 && rsp_chroma_red == 8'd0))
      else $error("invalid pixel carries data");
`endif

endmodule

// ----- tb/color_bar_checker.sv -----
// Checker for the color bar pixel generator: tracks settings writes, predicts each pixel
// beat and compares it with the result port. Depends on cbp_pkg for the register codes.
`timescale 1ns / 1ps

module color_bar_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [11:0] req_pixel_x,
   input  logic [11:0] req_pixel_y,
   input  logic [19:0] req_frame_number,
   input  logic        rsp_strobe,
   input  logic [7:0]  rsp_luma,
   input  logic [7:0]  rsp_chroma_blue,
   input  logic [7:0]  rsp_chroma_red,
   input  logic        rsp_pixel_valid,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_index,
   input  logic [47:0] csr_write_data,
   output int          error_count,
   output int          pixels_in_flight
);

   localparam int unsigned BARS = 7;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
      logic       valid;
   } pixel_type;

   logic [12:0] width;
   logic [12:0] height;
   logic [7:0]  fps;
   logic        line_en;
   logic [47:0] palette [4];
   pixel_type   expected_pixels [$];

   // palette color of the bar that holds column x
   function automatic logic [23:0] bar_color(input logic [11:0] x);
      int unsigned bar;
      logic [47:0] pair;
      bar = (int'(x) * BARS) / int'(width);
      if (bar > BARS - 1) bar = BARS - 1;
      pair = palette[bar >> 1];
      return bar[0] ? pair[47:24] : pair[23:0];
   endfunction

   // BT.601 studio range in 16.16 fixed point, returns {Y, Cb, Cr}
   function automatic logic [23:0] studio_ycc(input logic [23:0] rgb);
      int r;
      int g;
      int b;
      int ty;
      int tb;
      int tr;
      r  = rgb[23:16];
      g  = rgb[15:8];
      b  = rgb[7:0];
      ty = 16 * 65536 + 16843 * r + 33030 * g + 6423 * b;
      tb = 128 * 65536 - 9699 * r - 19071 * g + 28770 * b;
      tr = 128 * 65536 + 28770 * r - 24117 * g - 4653 * b;
      return {ty[23:16], tb[23:16], tr[23:16]};
   endfunction

   function automatic pixel_type pattern_pixel(input logic [11:0] x, input logic [11:0] y,
                                               input logic [19:0] frame);
      pixel_type        p;
      logic [23:0]      ycc_l;
      logic [23:0]      ycc_c;
      longint unsigned  line_x;
      int unsigned      line_w;
      int unsigned      band_row;
      p = '0;
      if (width == 0 || height == 0 || width[0] || height[0] || width > 4096 ||
          height > 4096 || fps == 0 || x >= width || y >= height)
         return p;
      ycc_l = studio_ycc(bar_color(x));
      ycc_c = studio_ycc(bar_color({x[11:1], 1'b0}));
      p.luma  = ycc_l[23:16];
      p.cb    = ycc_c[15:8];
      p.cr    = ycc_c[7:0];
      p.valid = 1'b1;
      // moving white line over the bottom tenth
      if (line_en) begin
         line_x   = ((longint'(frame) * longint'(width)) / longint'(fps)) % longint'(width);
         line_w   = width / 40;
         band_row = height - height / 10;
         if (y >= band_row && x >= line_x && x < line_x + line_w) p.luma = 8'd235;
      end
      return p;
   endfunction

   assign pixels_in_flight = expected_pixels.size();

   always @(posedge clock) begin
      pixel_type want;
      pixel_type got;
      if (reset) begin
         width   = 13'd1920;
         height  = 13'd1080;
         fps     = 8'd30;
         line_en = 1'b1;
         for (int i = 0; i < 4; i++) palette[i] = '0;
         expected_pixels.delete();
         error_count = 0;
      end else begin
         // compare the result beat before queuing this edge's request
         if (rsp_strobe) begin
            got = {rsp_luma, rsp_chroma_blue, rsp_chroma_red, rsp_pixel_valid};
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, got);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (want !== got) begin
                  $display({"%0t: mismatch expected Y=%0d Cb=%0d Cr=%0d valid=%0d,",
                            " got Y=%0d Cb=%0d Cr=%0d valid=%0d"},
                           $time, want.luma, want.cb, want.cr, want.valid,
                           got.luma, got.cb, got.cr, got.valid);
                  error_count++;
               end
            end
         end
         if (start && !busy)
            expected_pixels.push_back(pattern_pixel(req_pixel_x, req_pixel_y,
                                                    req_frame_number));
         if (csr_write_enable) begin
            case (csr_index)
               cbp_pkg::REG_FRAME_WIDTH:  width   = csr_write_data[12:0];
               cbp_pkg::REG_FRAME_HEIGHT: height  = csr_write_data[12:0];
               cbp_pkg::REG_FPS:          fps     = csr_write_data[7:0];
               cbp_pkg::REG_LINE_ENABLE:  line_en = csr_write_data[0];
               cbp_pkg::REG_PALETTE_0, cbp_pkg::REG_PALETTE_1,
               cbp_pkg::REG_PALETTE_2, cbp_pkg::REG_PALETTE_3:
                  palette[csr_index - cbp_pkg::REG_PALETTE_0] = csr_write_data;
               default: ;
            endcase
         end
      end
   end
endmodule

// ----- tb/testbench.sv -----
// Top of the color bar pixel generator testbench: clock, reset, settings and pixel stimulus.
// Depends on cbp_pkg, color_bar_pixel_generator and color_bar_checker.
`timescale 1ns / 1ps

module testbench;

   localparam int DRAIN_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [11:0] req_pixel_x = '0;
   logic [11:0] req_pixel_y = '0;
   logic [19:0] req_frame_number = '0;
   logic        rsp_strobe;
   logic [7:0]  rsp_luma;
   logic [7:0]  rsp_chroma_blue;
   logic [7:0]  rsp_chroma_red;
   logic        rsp_pixel_valid;
   logic        csr_write_enable = 1'b0;
   logic [3:0]  csr_index = '0;
   logic [47:0] csr_write_data = '0;
   int          error_count;
   int          pixels_in_flight;

   logic [12:0] cur_w;
   logic [12:0] cur_h;
   logic        gaps_on;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   color_bar_pixel_generator u_dut (.*);
   color_bar_checker u_checker (.*);

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // one register write, junk above the register width
   task automatic write_reg(input cbp_pkg::reg_index_type idx, input logic [47:0] value,
                            input logic [47:0] mask);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = (value & mask) | ({16'($urandom), $urandom} & ~mask);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // hold until every pixel is back, then let the pipeline empty
   task automatic wait_idle();
      while (pixels_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame(input logic [12:0] w, input logic [12:0] h, input logic [7:0] f,
                            input logic en);
      wait_idle();
      cur_w = w;
      cur_h = h;
      write_reg(cbp_pkg::REG_FRAME_WIDTH, 48'(w), 48'h1FFF);
      write_reg(cbp_pkg::REG_FRAME_HEIGHT, 48'(h), 48'h1FFF);
      write_reg(cbp_pkg::REG_FPS, 48'(f), 48'hFF);
      write_reg(cbp_pkg::REG_LINE_ENABLE, 48'(en), 48'h1);
   endtask

   task automatic set_palette();
      write_reg(cbp_pkg::REG_PALETTE_0, {16'($urandom), $urandom}, '1);
      write_reg(cbp_pkg::REG_PALETTE_1, {16'($urandom), $urandom}, '1);
      write_reg(cbp_pkg::REG_PALETTE_2, {16'($urandom), $urandom}, '1);
      write_reg(cbp_pkg::REG_PALETTE_3, {16'($urandom), $urandom}, '1);
      // unused indexes must leave the settings alone
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = 4'($urandom_range(8, 15));
      csr_write_data   = {16'($urandom), $urandom};
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // drive one pixel beat at the falling edge and hold until it is taken
   task automatic send_pixel(input logic [11:0] x, input logic [11:0] y,
                             input logic [19:0] f);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      gap = !gaps_on ? 0 : r < 50 ? 0 : r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 60);
      if (gap != 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start            = 1'b1;
      req_pixel_x      = x;
      req_pixel_y      = y;
      req_frame_number = f;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic end_burst();
      start = 1'b0;
   endtask

   // mostly in-frame pixels, half of them in the bottom tenth where the line lives
   task automatic random_pixel();
      logic [11:0] x;
      logic [11:0] y;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 75 && cur_w >= 1 && cur_h >= 1 && cur_w <= 4096 && cur_h <= 4096) begin
         x = 12'($urandom_range(0, cur_w - 1));
         y = ($urandom_range(0, 1) != 0) ?
             12'($urandom_range(cur_h - cur_h / 10, cur_h - 1)) :
             12'($urandom_range(0, cur_h - 1));
      end else begin
         x = 12'($urandom);
         y = 12'($urandom);
      end
      send_pixel(x, y, 20'($urandom));
   endtask

   initial begin
      int w;
      int h;
      int f;
      int r;
      gaps_on = 1'b1;
      cur_w = 13'd1920;
      cur_h = 13'd1080;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // settings after reset, black palette
      send_pixel(12'd0, 12'd0, 20'd0);
      send_pixel(12'd1919, 12'd1079, 20'hFFFFF);
      send_pixel(12'd1920, 12'd0, 20'd0);
      send_pixel(12'd0, 12'd1080, 20'd0);
      send_pixel(12'd4095, 12'd4095, 20'd7);
      end_burst();

      // small frame, line at column 0, two pixels wide, rows 18 and 19
      wait_idle();
      set_palette();
      set_frame(13'd80, 13'd20, 8'd1, 1'b1);
      send_pixel(12'd0, 12'd19, 20'd0);
      send_pixel(12'd1, 12'd18, 20'd1);
      send_pixel(12'd2, 12'd19, 20'd0);
      send_pixel(12'd1, 12'd17, 20'd0);
      send_pixel(12'd79, 12'd19, 20'hFFFFF);
      send_pixel(12'd11, 12'd5, 20'd3);
      end_burst();

      // largest frame at rate code 240, then the smallest frame at rate code 255
      set_frame(13'd4096, 13'd4096, 8'd240, 1'b1);
      send_pixel(12'd4095, 12'd4095, 20'hFFFFF);
      send_pixel(12'd4094, 12'd3700, 20'd12345);
      send_pixel(12'd0, 12'd4000, 20'd0);
      end_burst();
      set_frame(13'd2, 13'd2, 8'd255, 1'b0);
      send_pixel(12'd1, 12'd1, 20'hFFFFF);
      send_pixel(12'd2, 12'd0, 20'd0);
      end_burst();

      // invalid settings: odd, zero, oversized sizes and zero rate
      set_frame(13'd81, 13'd20, 8'd1, 1'b1);
      send_pixel(12'd3, 12'd3, 20'd0);
      end_burst();
      set_frame(13'd0, 13'd20, 8'd1, 1'b1);
      send_pixel(12'd0, 12'd0, 20'd0);
      end_burst();
      set_frame(13'd80, 13'd20, 8'd0, 1'b1);
      send_pixel(12'd4, 12'd4, 20'd9);
      end_burst();
      set_frame(13'd4098, 13'd8190, 8'd30, 1'b1);
      send_pixel(12'd4, 12'd4, 20'd9);
      end_burst();

      // random phases, each with fresh settings
      for (int phase = 0; phase < 12; phase++) begin
         r = $urandom_range(0, 99);
         w = r < 80 ? 2 * $urandom_range(1, 128) :
             r < 90 ? 2 * $urandom_range(1, 2048) : $urandom_range(0, 8191);
         r = $urandom_range(0, 99);
         h = r < 85 ? 2 * $urandom_range(1, 128) :
             r < 95 ? 2 * $urandom_range(1, 2048) : $urandom_range(0, 8191);
         r = $urandom_range(0, 99);
         f = r < 90 ? $urandom_range(1, 240) : $urandom_range(0, 255);
         set_frame(13'(w), 13'(h), 8'(f), $urandom_range(0, 3) != 0);
         set_palette();
         gaps_on = (phase % 4) != 3;
         for (int i = 0; i < 110; i++) random_pixel();
         end_burst();
      end

      while (pixels_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
